/* sv/ebs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ebs_pkg;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 512;
    localparam int FRAC_BITS_DEF  = 8;

    localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BAD_LOW    = 2'd2;
    localparam logic [1:0] REG_BAD_HIGH   = 2'd3;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef struct packed {
        logic [10:0] map_width;
        logic [9:0]  map_height;
        logic [7:0]  bad_low;
        logic [8:0]  bad_high;
    } cfg_t;
endpackage
`default_nettype wire

/* sv/ebs_bank.sv */
`timescale 1ns / 1ps
`default_nettype none
module ebs_bank #(
    parameter int AW = 17
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic [AW-1:0] raddr_a,
    output logic      [7:0]    rdata_a,
    input  wire logic [AW-1:0] raddr_b,
    output logic      [7:0]    rdata_b
);
    logic [7:0] mem [0:(1<<AW)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule
`default_nettype wire

/* sv/ebs_interp.sv */
`timescale 1ns / 1ps
`default_nettype none
module ebs_interp #(
    parameter int FB = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [7:0]    tl,
    input  wire logic [7:0]    tr,
    input  wire logic [7:0]    bl,
    input  wire logic [7:0]    br,
    input  wire logic [FB-1:0] fx,
    input  wire logic [FB-1:0] fy,
    input  wire logic [7:0]    bad_low,
    input  wire logic [8:0]    bad_high,
    output logic               out_valid,
    output logic [15:0]        level,
    output logic               bad
);
    localparam int LW = 8 + FB + 1;
    localparam int VW = LW + FB + 1;

    logic [LW-1:0] left_reg, right_reg, left_next, right_next;
    logic [FB-1:0] fx_reg;
    logic          bad_reg, bad_next, v1_reg;
    logic [VW-1:0] val;
    logic [FB:0]   one, fy_e, fx_e;

    assign one  = {1'b1, {FB{1'b0}}};
    assign fy_e = {1'b0, fy};
    assign fx_e = {1'b0, fx_reg};

    function automatic logic chk(input logic [7:0] p, input logic [7:0] lo, input logic [8:0] hi);
        chk = (p < lo) || ({1'b0, p} >= hi);
    endfunction

    always_comb
    begin
        left_next  = LW'(tl * (one - fy_e)) + LW'(bl * fy_e);
        right_next = LW'(tr * (one - fy_e)) + LW'(br * fy_e);
        bad_next   = chk(tl, bad_low, bad_high) || chk(tr, bad_low, bad_high)
                  || chk(bl, bad_low, bad_high) || chk(br, bad_low, bad_high);
        val = VW'(left_reg * (one - fx_e)) + VW'(right_reg * fx_e);
    end

    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        right_reg <= right_next;
        fx_reg    <= fx;
        bad_reg   <= bad_next;
        level     <= 16'(val >> (2 * FB - 8));
        bad       <= bad_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            v1_reg    <= in_valid;
            out_valid <= v1_reg;
        end
    end
endmodule
`default_nettype wire

/* sv/equirect_bilinear_sampler.sv */
// a sample's result strobe passes through s1_reg to s4_reg, then the interpolator's v1_reg and out_valid
// throughput: one item per cycle; busy never rises, writes and samples interleave
// two pixel banks split by row parity, two read ports each; writes land through a delay line
// reset clears control registers and loads config defaults; pixel memory is undefined until written
// the receiver cannot stall: each result is shown for one cycle only
`timescale 1ns / 1ps
`default_nettype none
module equirect_bilinear_sampler
    import ebs_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        action,
    input  wire logic [9:0]  write_col,
    input  wire logic [8:0]  write_row,
    input  wire logic [7:0]  write_level,
    input  wire logic signed [16:0] lon_angle,
    input  wire logic signed [15:0] lat_angle,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data,
    output logic             result_valid,
    output logic [15:0]      sample_level,
    output logic             bad_flag
);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int BAW = CW + RW - 1;
    localparam int FB  = FRAC_BITS;
    localparam int PW  = 36 + FB;

    cfg_t cfg_reg;
    logic [16:0] w_sat, h_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.map_width  <= 11'd1024;
            cfg_reg.map_height <= 10'd512;
            cfg_reg.bad_low    <= 8'd2;
            cfg_reg.bad_high   <= 9'd253;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAP_WIDTH:  cfg_reg.map_width  <= cfg_data;
                REG_MAP_HEIGHT: cfg_reg.map_height <= cfg_data[9:0];
                REG_BAD_LOW:    cfg_reg.bad_low    <= cfg_data[7:0];
                REG_BAD_HIGH:   cfg_reg.bad_high   <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        w_sat = {6'd0, cfg_reg.map_width};
        if (w_sat < 17'd2) w_sat = 17'd2;
        if (w_sat > 17'(MAX_WIDTH)) w_sat = 17'(MAX_WIDTH);
        h_sat = {7'd0, cfg_reg.map_height};
        if (h_sat < 17'd2) h_sat = 17'd2;
        if (h_sat > 17'(MAX_HEIGHT)) h_sat = 17'(MAX_HEIGHT);
    end

    assign busy = 1'b0;
    logic acc;
    assign acc = start && !busy;

    // stage 1: products
    logic              s1_reg;
    logic signed [PW-1:0] px_reg, py_reg;
    always_ff @(posedge clk)
    begin
        px_reg <= PW'($signed(lon_angle) * $signed({1'b0, w_sat}));
        py_reg <= PW'($signed(lat_angle) * $signed({1'b0, h_sat}));
    end

    // stage 2: fixed-point coordinates, floor via arithmetic shift
    logic signed [PW-1:0] xn, yn;
    logic signed [PW-1:0] xf_reg, yf_reg;
    logic s2_reg;
    always_comb
    begin
        xn = (px_reg <<< FB) + ($signed(PW'(w_sat - 17'd1)) <<< (FB + 15));
        yn = ($signed(PW'(h_sat - 17'd1)) <<< (FB + 14)) - (py_reg <<< FB);
    end
    always_ff @(posedge clk)
    begin
        xf_reg <= xn >>> 16;
        yf_reg <= yn >>> 15;
    end

    // stage 3: wrap and clamp
    logic signed [PW-1:0] ix, iy;
    logic signed [PW-1:0] c0w, c1w;
    logic [CW-1:0] c0_reg, c1_reg;
    logic [RW-1:0] r0_reg, r1_reg;
    logic [FB-1:0] fx3_reg, fy3_reg;
    logic s3_reg;
    logic signed [PW-1:0] ws, hs;
    always_comb
    begin
        ix = xf_reg >>> FB;
        iy = yf_reg >>> FB;
        ws = $signed(PW'(w_sat));
        hs = $signed(PW'(h_sat));
        c0w = (ix < 0) ? ix + ws : ((ix >= ws) ? ix - ws : ix);
        c1w = (c0w == ws - 1) ? '0 : c0w + 1;
    end
    always_ff @(posedge clk)
    begin
        c0_reg  <= CW'(c0w);
        c1_reg  <= CW'(c1w);
        r0_reg  <= (iy < 0) ? '0 : (iy > hs - 1) ? RW'(hs - 1) : RW'(iy);
        r1_reg  <= (iy + 1 < 0) ? '0 : (iy + 1 > hs - 1) ? RW'(hs - 1) : RW'(iy + 1);
        fx3_reg <= FB'(xf_reg);
        fy3_reg <= FB'(yf_reg);
    end

    // write path delayed to line up with the sample read stage
    logic          wsel;
    logic [2:0]    wv_reg;
    logic [RW-1:0] wrow_reg [0:2];
    logic [CW-1:0] wcol_reg [0:2];
    logic [7:0]    wlvl_reg [0:2];
    assign wsel = acc && (action == ACT_WRITE)
               && ({22'd0, write_col} < 32'(MAX_WIDTH))
               && ({23'd0, write_row} < 32'(MAX_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wv_reg <= '0;
        end
        else
        begin
            wv_reg <= {wv_reg[1:0], wsel};
        end
    end

    always_ff @(posedge clk)
    begin
        wrow_reg[0] <= RW'(write_row);
        wcol_reg[0] <= CW'(write_col);
        wlvl_reg[0] <= write_level;
        for (int k = 1; k < 3; k++)
        begin
            wrow_reg[k] <= wrow_reg[k-1];
            wcol_reg[k] <= wcol_reg[k-1];
            wlvl_reg[k] <= wlvl_reg[k-1];
        end
    end

    // bank g holds rows of parity g
    logic [RW-1:0] rsel [0:1];
    logic          r0odd, same_row;
    always_comb
    begin
        r0odd    = r0_reg[0];
        same_row = (r0_reg == r1_reg);
        rsel[0]  = r0odd ? r1_reg : r0_reg;
        rsel[1]  = r0odd ? r0_reg : r1_reg;
    end

    logic [7:0] qa [0:1];
    logic [7:0] qb [0:1];

    genvar g;
    generate
        for (g = 0; g < 2; g++)
        begin : g_bank
            ebs_bank #(.AW(BAW)) u_bank (
                .clk     (clk),
                .we      (wv_reg[2] && (wrow_reg[2][0] == 1'(g))),
                .waddr   (BAW'({wrow_reg[2] >> 1, wcol_reg[2]})),
                .wdata   (wlvl_reg[2]),
                .raddr_a (BAW'({rsel[g] >> 1, c0_reg})),
                .rdata_a (qa[g]),
                .raddr_b (BAW'({rsel[g] >> 1, c1_reg})),
                .rdata_b (qb[g])
            );
        end
    endgenerate

    logic r0odd4_reg, same4_reg;
    logic [FB-1:0] fx4_reg, fy4_reg;
    logic s4_reg;
    always_ff @(posedge clk)
    begin
        r0odd4_reg <= r0odd;
        same4_reg  <= same_row;
        fx4_reg    <= fx3_reg;
        fy4_reg    <= fy3_reg;
    end

    logic [7:0] tl, tr, bl, br;
    always_comb
    begin
        tl = qa[r0odd4_reg];
        tr = qb[r0odd4_reg];
        bl = same4_reg ? qa[r0odd4_reg] : qa[~r0odd4_reg];
        br = same4_reg ? qb[r0odd4_reg] : qb[~r0odd4_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= 1'b0;
            s2_reg <= 1'b0;
            s3_reg <= 1'b0;
            s4_reg <= 1'b0;
        end
        else
        begin
            s1_reg <= acc && (action == ACT_SAMPLE);
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
            s4_reg <= s3_reg;
        end
    end

    ebs_interp #(.FB(FB)) u_interp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s4_reg),
        .tl        (tl),
        .tr        (tr),
        .bl        (bl),
        .br        (br),
        .fx        (fx4_reg),
        .fy        (fy4_reg),
        .bad_low   (cfg_reg.bad_low),
        .bad_high  (cfg_reg.bad_high),
        .out_valid (result_valid),
        .level     (sample_level),
        .bad       (bad_flag)
    );

    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        s4_reg |=> ##1 result_valid) else $error("sample lost in pipeline");
    a_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
        (start && action == ACT_WRITE) |=> !s1_reg) else $error("write made a result");
    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        s3_reg |-> (17'(c0_reg) < w_sat) && (17'(c1_reg) < w_sat))
        else $error("column out of range");
endmodule
`default_nettype wire

/* dv/tb_equirect_bilinear_sampler.sv */
`timescale 1ns / 1ps
module tb_equirect_bilinear_sampler;
    import ebs_pkg::*;

    localparam int STORE_W = MAX_WIDTH_DEF;
    localparam int STORE_H = MAX_HEIGHT_DEF;
    localparam int ONE     = 1 << FRAC_BITS_DEF;

    typedef struct {
        logic               act;
        logic [9:0]         col;
        logic [8:0]         row;
        logic [7:0]         lvl;
        logic signed [16:0] lon;
        logic signed [15:0] lat;
    } map_item_t;

    typedef struct {
        logic [15:0] level;
        logic        bad;
    } sample_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               action;
    logic [9:0]         write_col;
    logic [8:0]         write_row;
    logic [7:0]         write_level;
    logic signed [16:0] lon_angle;
    logic signed [15:0] lat_angle;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [10:0]        cfg_data;
    logic               result_valid;
    logic [15:0]        sample_level;
    logic               bad_flag;

    map_item_t   item_q[$];
    sample_t     sample_due_q[$];
    logic [7:0]  pix_level[0:STORE_W*STORE_H-1];
    bit          pix_known[0:STORE_W*STORE_H-1];
    logic [10:0] width_reg;
    logic [9:0]  height_reg;
    logic [7:0]  low_reg;
    logic [8:0]  high_reg;
    int          mismatches;
    int          gap;
    bit          took;
    bit          calm;

    equirect_bilinear_sampler i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .write_col    (write_col),
        .write_row    (write_row),
        .write_level  (write_level),
        .lon_angle    (lon_angle),
        .lat_angle    (lat_angle),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .sample_level (sample_level),
        .bad_flag     (bad_flag)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint map_w();
        return width_reg < 2 ? 2 : (width_reg > STORE_W ? STORE_W : width_reg);
    endfunction

    function automatic longint map_h();
        return height_reg < 2 ? 2 : (height_reg > STORE_H ? STORE_H : height_reg);
    endfunction

    function automatic void find_taps(input logic signed [16:0] lon,
                                      input logic signed [15:0] lat,
                                      output longint c0, output longint c1, output longint r0,
                                      output longint r1, output longint fx, output longint fy);
        longint w, h, xf, yf, ix, iy;
        w  = map_w();
        h  = map_h();
        xf = (longint'(lon) * w * ONE + (w - 1) * (ONE / 2) * 65536) >>> 16;
        yf = ((h - 1) * (ONE / 2) * 32768 - longint'(lat) * h * ONE) >>> 15;
        ix = xf >>> FRAC_BITS_DEF;
        iy = yf >>> FRAC_BITS_DEF;
        fx = xf - ix * ONE;
        fy = yf - iy * ONE;
        c0 = ix % w;
        if (c0 < 0)
            c0 += w;
        c1 = (ix + 1) % w;
        if (c1 < 0)
            c1 += w;
        r0 = iy < 0 ? 0 : (iy > h - 1 ? h - 1 : iy);
        r1 = iy + 1 < 0 ? 0 : (iy + 1 > h - 1 ? h - 1 : iy + 1);
    endfunction

    function automatic sample_t predict_sample(logic signed [16:0] lon, logic signed [15:0] lat);
        longint  c0, c1, r0, r1, fx, fy, lft, rgt, val;
        int      tap[4];
        sample_t res;
        find_taps(lon, lat, c0, c1, r0, r1, fx, fy);
        tap[0] = pix_level[r0 * STORE_W + c0];
        tap[1] = pix_level[r0 * STORE_W + c1];
        tap[2] = pix_level[r1 * STORE_W + c0];
        tap[3] = pix_level[r1 * STORE_W + c1];
        res.bad = 1'b0;
        foreach (tap[k])
            if (tap[k] < int'(low_reg) || tap[k] >= int'(high_reg))
                res.bad = 1'b1;
        lft = tap[0] * (ONE - fy) + tap[2] * fy;
        rgt = tap[1] * (ONE - fy) + tap[3] * fy;
        val = (lft * (ONE - fx) + rgt * fx) >> (2 * FRAC_BITS_DEF - 8);
        res.level = val[15:0];
        return res;
    endfunction

    // result check, then prediction of whatever transfers at this edge
    always @(posedge clk)
    begin
        sample_t exp_s;
        took = 1'b0;
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (sample_due_q.size() == 0)
                begin
                    $display("%0t: unexpected result level=%h bad=%b", $time,
                             sample_level, bad_flag);
                    mismatches++;
                end
                else
                begin
                    exp_s = sample_due_q.pop_front();
                    if (sample_level !== exp_s.level)
                    begin
                        $display("%0t: sample_level expected %h actual %h", $time,
                                 exp_s.level, sample_level);
                        mismatches++;
                    end
                    if (bad_flag !== exp_s.bad)
                    begin
                        $display("%0t: bad_flag expected %b actual %b", $time,
                                 exp_s.bad, bad_flag);
                        mismatches++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MAP_WIDTH:  width_reg  = cfg_data;
                    REG_MAP_HEIGHT: height_reg = cfg_data[9:0];
                    REG_BAD_LOW:    low_reg    = cfg_data[7:0];
                    REG_BAD_HIGH:   high_reg   = cfg_data[8:0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                took = 1'b1;
                if (action == ACT_WRITE)
                    pix_level[int'(write_row) * STORE_W + int'(write_col)] = write_level;
                else
                    sample_due_q = {sample_due_q, predict_sample(lon_angle, lat_angle)};
            end
        end
    end

    always @(negedge clk)
    begin
        map_item_t it;
        if (rst_n && !(start && !took))
        begin
            if (gap > 0)
            begin
                start <= 1'b0;
                gap--;
            end
            else if (item_q.size() > 0)
            begin
                it = item_q.pop_front();
                start       <= 1'b1;
                action      <= it.act;
                write_col   <= it.col;
                write_row   <= it.row;
                write_level <= it.lvl;
                lon_angle   <= it.lon;
                lat_angle   <= it.lat;
                if (!calm && $urandom_range(0, 5) == 0)
                    gap = $urandom_range(1, 9);
            end
            else
                start <= 1'b0;
        end
    end

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(0, 3));
            3: return 8'($urandom_range(250, 255));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic add_write(int col, int row, logic [7:0] lvl);
        map_item_t it;
        it = '{ACT_WRITE, 10'(col), 9'(row), lvl, 17'($urandom), 16'($urandom)};
        pix_known[row * STORE_W + col] = 1'b1;
        item_q = {item_q, it};
    endtask

    // any tap never written gets a write first so no undefined read happens
    task automatic add_sample(logic signed [16:0] lon, logic signed [15:0] lat);
        longint    c0, c1, r0, r1, fx, fy;
        longint    cs[4], rs[4];
        map_item_t it;
        find_taps(lon, lat, c0, c1, r0, r1, fx, fy);
        cs = '{c0, c1, c0, c1};
        rs = '{r0, r0, r1, r1};
        foreach (cs[k])
            if (!pix_known[rs[k] * STORE_W + cs[k]])
                add_write(int'(cs[k]), int'(rs[k]), pick_level());
        it = '{ACT_SAMPLE, 10'($urandom), 9'($urandom), 8'($urandom), lon, lat};
        item_q = {item_q, it};
    endtask

    task automatic add_random(int count);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) < 4)
            begin
                if ($urandom_range(0, 1))
                    add_write($urandom_range(0, int'(map_w()) - 1),
                              $urandom_range(0, int'(map_h()) - 1), pick_level());
                else
                    add_write($urandom_range(0, STORE_W - 1), $urandom_range(0, STORE_H - 1),
                              pick_level());
            end
            else if ($urandom_range(0, 9) < 7)
                add_sample(17'($signed($urandom_range(0, 65536)) - 32768),
                           16'($signed($urandom_range(0, 32768)) - 16384));
            else
                add_sample(17'($urandom), 16'($urandom));
        end
    endtask

    task automatic drain();
        while (item_q.size() > 0 || start || sample_due_q.size() > 0 || gap > 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [10:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_map(int w, int h, int lo, int hi);
        drain();
        set_reg(REG_MAP_WIDTH, 11'(w));
        set_reg(REG_MAP_HEIGHT, 11'(h));
        set_reg(REG_BAD_LOW, 11'(lo));
        set_reg(REG_BAD_HIGH, 11'(hi));
        @(negedge clk);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        action      = ACT_WRITE;
        write_col   = '0;
        write_row   = '0;
        write_level = '0;
        lon_angle   = '0;
        lat_angle   = '0;
        cfg_we      = 1'b0;
        cfg_index   = REG_MAP_WIDTH;
        cfg_data    = '0;
        width_reg   = 11'd1024;
        height_reg  = 10'd512;
        low_reg     = 8'd2;
        high_reg    = 9'd253;
        mismatches  = 0;
        gap         = 0;
        took        = 1'b0;
        calm        = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // corners of the angle range and of the store, default map
        add_write(STORE_W - 1, STORE_H - 1, 8'd255);
        add_write(0, 0, 8'd0);
        add_write(1023, 0, 8'd1);
        add_write(0, 511, 8'd254);
        add_sample(17'sd0, 16'sd0);
        add_sample(-17'sd32768, 16'sd16384);
        add_sample(17'sd32768, -16'sd16384);
        add_sample(-17'sd65536, 16'sh7fff);
        add_sample(17'sd65535, -16'sd32768);
        add_sample(17'sd1, -16'sd1);
        add_sample(-17'sd1, 16'sd1);
        add_sample(17'sd64, 16'sd32);
        add_random(50);

        set_map(2, 2, 0, 256);
        add_sample(17'sd0, 16'sd0);
        add_sample(-17'sd32768, 16'sd16384);
        add_random(100);
        set_map(0, 1, 255, 0);
        add_random(80);
        set_map(2047, 1023, 10, 511);
        add_random(40);
        set_map(1024, 512, 0, 255);
        add_random(40);
        set_map(3, 5, 40, 200);
        add_random(100);
        set_map($urandom_range(2, 64), $urandom_range(2, 32), $urandom_range(0, 20),
                $urandom_range(230, 256));
        add_random(100);
        set_map(1000, 3, 2, 253);
        drain();
        calm = 1'b1;
        add_random(60);
        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && sample_due_q.size() == 0)
            $display("tb_equirect_bilinear_sampler: PASS");
        else
            $display("tb_equirect_bilinear_sampler: FAIL");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("tb_equirect_bilinear_sampler: FAIL");
        $finish;
    end
endmodule

/* sim.f */
sv/ebs_pkg.sv
sv/ebs_bank.sv
sv/ebs_interp.sv
sv/equirect_bilinear_sampler.sv
dv/tb_equirect_bilinear_sampler.sv
